>>> hw/rtl/lcmlt_pkg.sv
// ----------------------------------------------------------------------------
// lcmlt_pkg
// shared types and codes of the max line tree: item structs, operation and
// status codes, node word layout and sequencer states
// ----------------------------------------------------------------------------
package lcmlt_pkg;

  localparam int ACT_W = 11;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic        [1:0]  operation;
    logic        [9:0]  point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] line_slope;
    logic signed [31:0] line_intercept;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] best_value;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
  } node_word_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_LEVEL,
    S_INS_NODE,
    S_INS_XU,
    S_INS_XC,
    S_INS_EVAL,
    S_INS_DECIDE,
    S_Q_SEARCH,
    S_Q_CMP,
    S_Q_EQ,
    S_Q_LEVEL,
    S_Q_NODE,
    S_Q_MUL,
    S_Q_ACC,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/li_chao_max_line_tree.sv
// ----------------------------------------------------------------------------
// li_chao_max_line_tree
// li chao tree keeping lines a*x+b over loaded ascending coordinates,
// answering the maximum at a loaded x
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  in       | input     | in_valid/in_stall  | in_data   (in_item_t)
//  out      | output    | out_valid/out_stall| out_data  (out_item_t)
//  cfg      | input     | cfg_valid/cfg_ready| cfg_data  (active_points)
//
//  load: the position is written as the item is taken. insert: per tree level,
//  INS_LEVEL, INS_NODE, INS_XU and INS_XC read memory, INS_EVAL makes six
//  evaluations on the one shared 32x32 multiplier, then INS_DECIDE; up to
//  clog2(MAX_POINTS)+1 levels. query: Q_SEARCH and Q_CMP per search step,
//  Q_EQ for the equality read, then Q_LEVEL, Q_NODE, Q_MUL, Q_ACC per level.
//  after reset a clearing pass empties all 2*MAX_POINTS node words; in_stall
//  stays high during it, cfg transfers are taken at any time. in_stall is high
//  while an item is in work; a result held by out_stall keeps it in S_DONE.
// ----------------------------------------------------------------------------
module li_chao_max_line_tree
  import lcmlt_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ACT_W-1:0] cfg_data
);

  localparam int NODE_DEPTH = 2 * MAX_POINTS;
  localparam int PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;   // position address
  localparam int CW  = $clog2(MAX_POINTS + 1);                      // slot counts
  localparam int NAW = $clog2(NODE_DEPTH);                          // node address
  localparam int IW  = NAW + 1;                                     // node index

  state_t state, state_next;

  // config
  logic [ACT_W-1:0] active;
  logic [CW-1:0]    span_n;

  // sequencer registers
  logic [IW:0]        clr_cnt;
  logic [IW-1:0]      idx;
  logic [CW-1:0]      lb, ub, first, count;
  logic signed [31:0] ca, cb, na, nb, xl, xu, xc, qx;
  logic [2:0]         step;
  logic signed [63:0] val [6];
  logic signed [63:0] prod, best;
  logic signed [31:0] addb;
  logic               have;
  logic signed [63:0] res_best;
  logic [1:0]         res_status;

  // memory ports
  logic             pos_we;
  logic [PW-1:0]    pos_waddr, pos_raddr;
  logic [31:0]      pos_wdata, pos_rdata;
  logic             node_we;
  logic [NAW-1:0]   node_waddr, node_raddr;
  node_word_t       node_wdata, node_rdata;

  // datapath helpers
  logic               in_xfer;
  logic [CW-1:0]      mid, half;
  logic signed [31:0] mul_a, mul_x, mul_b;
  logic signed [63:0] sum;
  logic               dom_keep, dom_new, swap, go_left;
  logic signed [63:0] node_xl, car_xl;
  logic               q_take;
  logic signed [63:0] q_max;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= ACT_W'(MAX_POINTS);
    end else if (cfg_valid && cfg_ready) begin
      active <= cfg_data;
    end
  end

  // zero counts as one, above the store saturates
  always_comb begin
    if (active == '0) begin
      span_n = CW'(1);
    end else if (32'(active) > MAX_POINTS) begin
      span_n = CW'(MAX_POINTS);
    end else begin
      span_n = CW'(active);
    end
  end

  assign mid  = CW'(({1'b0, lb} + {1'b0, ub}) >> 1);
  assign half = count >> 1;

  lcmlt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  lcmlt_ram #(.WIDTH($bits(node_word_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = ca;
    mul_x = qx;
    mul_b = cb;
    if (state == S_INS_EVAL) begin
      case (step)
        3'd0: begin mul_a = ca; mul_b = cb; mul_x = xl; end
        3'd1: begin mul_a = na; mul_b = nb; mul_x = xl; end
        3'd2: begin mul_a = ca; mul_b = cb; mul_x = xu; end
        3'd3: begin mul_a = na; mul_b = nb; mul_x = xu; end
        3'd4: begin mul_a = ca; mul_b = cb; mul_x = xc; end
        default: begin mul_a = na; mul_b = nb; mul_x = xc; end
      endcase
    end
  end

  assign sum = prod + 64'(addb);

  // insert decision on the six evaluations
  assign dom_keep = (val[0] >= val[1]) && (val[2] >= val[3]);
  assign dom_new  = (val[0] <= val[1]) && (val[2] <= val[3]);
  assign swap     = val[4] < val[5];
  assign node_xl  = swap ? val[1] : val[0];
  assign car_xl   = swap ? val[0] : val[1];
  assign go_left  = node_xl <= car_xl;

  // query running maximum
  assign q_take = !have || (sum > best);
  assign q_max  = q_take ? sum : best;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == (IW+1)'(NODE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (in_data.operation)
            OP_INSERT: state_next = S_INS_LEVEL;
            OP_QUERY:  state_next = S_Q_SEARCH;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INS_LEVEL: begin
        state_next = (32'(idx) >= NODE_DEPTH) ? S_DONE : S_INS_NODE;
      end
      S_INS_NODE:   state_next = node_rdata.valid ? S_INS_XU : S_DONE;
      S_INS_XU:     state_next = S_INS_XC;
      S_INS_XC:     state_next = S_INS_EVAL;
      S_INS_EVAL:   state_next = (step == 3'd6) ? S_INS_DECIDE : S_INS_EVAL;
      S_INS_DECIDE: state_next = (dom_keep || dom_new) ? S_DONE : S_INS_LEVEL;
      S_Q_SEARCH: begin
        if (count != '0) begin
          state_next = S_Q_CMP;
        end else begin
          state_next = (first >= span_n) ? S_DONE : S_Q_EQ;
        end
      end
      S_Q_CMP: state_next = S_Q_SEARCH;
      S_Q_EQ:  state_next = ($signed(pos_rdata) != qx) ? S_DONE : S_Q_LEVEL;
      S_Q_LEVEL: begin
        state_next = (32'(idx) >= NODE_DEPTH) ? S_DONE : S_Q_NODE;
      end
      S_Q_NODE: state_next = node_rdata.valid ? S_Q_MUL : S_DONE;
      S_Q_MUL:  state_next = S_Q_ACC;
      S_Q_ACC:  state_next = (lb == ub) ? S_DONE : S_Q_LEVEL;
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    in_stall   = (state != S_IDLE);
    pos_we     = 1'b0;
    pos_waddr  = PW'(in_data.point_index);
    pos_wdata  = in_data.x_value;
    pos_raddr  = PW'(lb);
    node_we    = 1'b0;
    node_waddr = NAW'(idx);
    node_wdata = '{valid: 1'b1, slope: na, intercept: nb};
    node_raddr = NAW'(idx);
    case (state)
      S_CLEAR: begin
        node_we    = 1'b1;
        node_waddr = NAW'(clr_cnt);
        node_wdata = '0;
      end
      S_IDLE: begin
        pos_we = in_xfer && (in_data.operation == OP_LOAD) &&
                 (32'(in_data.point_index) < MAX_POINTS);
      end
      S_INS_NODE:   pos_raddr = PW'(ub);
      S_INS_XU:     pos_raddr = PW'(mid);
      S_INS_DECIDE: node_we = !dom_keep && (dom_new || swap);
      S_Q_SEARCH: begin
        pos_raddr = (count != '0) ? PW'(first + half) : PW'(first);
      end
      default: ;
    endcase
    if (state == S_INS_NODE && !node_rdata.valid) begin
      node_we = 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_x;
    addb <= mul_b;
    case (state)
      S_IDLE: begin
        res_best   <= '0;
        res_status <= ST_OK;
        na    <= in_data.line_slope;
        nb    <= in_data.line_intercept;
        qx    <= in_data.x_value;
        idx   <= IW'(1);
        lb    <= '0;
        ub    <= span_n - CW'(1);
        first <= '0;
        count <= span_n;
        have  <= 1'b0;
      end
      S_INS_NODE: begin
        ca   <= node_rdata.slope;
        cb   <= node_rdata.intercept;
        xl   <= $signed(pos_rdata);
        step <= '0;
      end
      S_INS_XU: xu <= $signed(pos_rdata);
      S_INS_XC: xc <= $signed(pos_rdata);
      S_INS_EVAL: begin
        step <= step + 3'd1;
        if (step != 3'd0) val[step - 3'd1] <= sum;
      end
      S_INS_DECIDE: begin
        if (swap) begin
          na <= ca;
          nb <= cb;
        end
        if (go_left) begin
          idx <= idx << 1;
          ub  <= mid;
        end else begin
          idx <= (idx << 1) | IW'(1);
          lb  <= mid + CW'(1);
        end
      end
      S_Q_SEARCH: begin
        if (count == '0 && first >= span_n) res_status <= ST_ABSENT;
      end
      S_Q_CMP: begin
        if ($signed(pos_rdata) < qx) begin
          first <= first + half + CW'(1);
          count <= count - half - CW'(1);
        end else begin
          count <= half;
        end
      end
      S_Q_EQ: begin
        if ($signed(pos_rdata) != qx) res_status <= ST_ABSENT;
      end
      S_Q_LEVEL: res_best <= best;
      S_Q_NODE: begin
        ca <= node_rdata.slope;
        cb <= node_rdata.intercept;
        // an empty root means no line at all
        if (!node_rdata.valid && idx == IW'(1)) res_status <= ST_EMPTY;
        res_best <= (!node_rdata.valid && idx == IW'(1)) ? 64'sd0 : best;
      end
      S_Q_ACC: begin
        best     <= q_max;
        have     <= 1'b1;
        res_best <= q_max;
        if (first <= mid) begin
          idx <= idx << 1;
          ub  <= mid;
        end else begin
          idx <= (idx << 1) | IW'(1);
          lb  <= mid + CW'(1);
        end
      end
      default: ;
    endcase
    if (state == S_IDLE) best <= '0;
  end

  // control registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + (IW+1)'(1);
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_data.best_value <= res_best;
      out_data.status     <= res_status;
    end
  end

endmodule

>>> hw/rtl/lcmlt_ram.sv
// ----------------------------------------------------------------------------
// lcmlt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lcmlt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
